// ===== rtl/cafs_pkg.sv =====
`timescale 1ns / 1ps

package cafs_pkg;

	// defaults for the top-level parameters
	localparam int MAX_COARSE_STEPS_DEF = 32;
	localparam int MAX_FINE_STEPS_DEF   = 32;
	localparam int POS_BITS_DEF         = 10;

	// fixed field widths
	localparam int FV_W    = 31;
	localparam int STEPS_W = 6;
	localparam int PCT_W   = 7;
	localparam int FALL_W  = 3;
	localparam int SETL_W  = 2;
	localparam int PROD_W  = FV_W + PCT_W;

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 31;

	localparam logic [CFG_IW-1:0] CFG_SCAN_START   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_SCAN_END     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_COARSE_STEPS = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_FINE_STEPS   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_MIN_PEAK     = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_DROP_RATIO   = 3'd5;

	// register reset values
	localparam int SCAN_START_RST   = 0;
	localparam int SCAN_END_RST     = 1023;
	localparam int COARSE_STEPS_RST = 16;
	localparam int FINE_STEPS_RST   = 10;
	localparam int MIN_PEAK_RST     = 10000;
	localparam int DROP_RATIO_RST   = 70;

	// request function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	// search constants
	localparam int MIN_COARSE    = 4;
	localparam int MIN_FINE      = 2;
	localparam int START_SETTLE  = 3;
	localparam int MOVE_SETTLE   = 1;
	localparam int FALL_LIMIT    = 3;
	localparam int FALL_MAX      = 7;
	localparam int TRACK_FROM    = 3;
	localparam int WIN_SPAN      = 4;
	localparam int WIN_LOW_EDGE  = 2;
	localparam int WIN_HIGH_EDGE = 3;
	localparam int PCT_SCALE     = 100;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COARSE,
		PH_FINE,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MULT,
		S_TRACK,
		S_DECIDE,
		S_CALL,
		S_WAIT,
		S_EMIT
	} seq_t;

	// what an interpolation result is used for
	typedef enum logic [1:0] {
		CALL_WLO,
		CALL_WHI,
		CALL_POS,
		CALL_FPOS
	} call_t;

endpackage

// ===== rtl/cafs_ifs.sv =====
`timescale 1ns / 1ps

interface cafs_item_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [cafs_pkg::FV_W-1:0]  focus_value;

	modport source (output valid, output func, output focus_value, input ready);
	modport sink (input valid, input func, input focus_value, output ready);
endinterface

interface cafs_result_if #(
	parameter int POS_BITS = cafs_pkg::POS_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic                       move_valid;
	logic [POS_BITS-1:0]        lens_target;
	logic                       done_res;
	logic [cafs_pkg::FV_W-1:0]  peak_value;

	modport source (
		output valid, output move_valid, output lens_target, output done_res,
		output peak_value, input ready
	);
	modport sink (
		input valid, input move_valid, input lens_target, input done_res,
		input peak_value, output ready
	);
endinterface

// ===== rtl/cafs_interp.sv =====
`timescale 1ns / 1ps

// a + round_half_up(i*(b-a)/n) as floor((2na + 2i(b-a) + n) / 2n),
// restoring division, one quotient bit per cycle
module cafs_interp #(
	parameter int POS_BITS = cafs_pkg::POS_BITS_DEF,
	parameter int NB       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [POS_BITS-1:0] a,
	input  logic [POS_BITS-1:0] b,
	input  logic [NB-1:0]       idx,
	input  logic [NB-1:0]       n,
	output logic                done,
	output logic [POS_BITS-1:0] pos
);

	localparam int SW = POS_BITS + NB + 3;
	localparam int CW = $clog2(POS_BITS + 1);

	logic [NB-1:0]        i_cl;
	logic signed [SW-1:0] a_x, b_x, n_x, i_x, num_c;
	logic [NB+1:0]        trial;
	logic                 ge;
	logic [NB+1:0]        diff;

	logic [NB:0]          rem_q;
	logic [NB:0]          den_q;
	logic [POS_BITS-1:0]  sh_q;
	logic [POS_BITS-1:0]  quo_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	assign i_cl  = (idx > n) ? n : idx;
	assign a_x   = SW'(a);
	assign b_x   = SW'(b);
	assign n_x   = SW'(n);
	assign i_x   = SW'(i_cl);
	// never negative: the point lies between a and b
	assign num_c = ((n_x * a_x) <<< 1) + ((i_x * (b_x - a_x)) <<< 1) + n_x;

	assign trial = {rem_q, sh_q[POS_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(POS_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_c[POS_BITS+NB:POS_BITS];
			sh_q  <= num_c[POS_BITS-1:0];
			den_q <= {n, 1'b0};
		end else if (busy_q) begin
			rem_q <= ge ? diff[NB:0] : trial[NB:0];
			sh_q  <= sh_q << 1;
			quo_q <= {quo_q[POS_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign pos  = quo_q;

endmodule

// ===== rtl/contrast_af_two_pass_search.sv =====
`timescale 1ns / 1ps

// channel   dir  payload                                         moves when
// item      in   func, focus_value                               valid && ready
// result    out  move_valid, lens_target, done_res, peak_value   valid && ready
// cfg       in   cfg_idx, cfg_data                               cfg_we
//
// one request at a time; ready is high only between requests;
// a coarse or fine move waits on the shared interpolation divider (one quotient
// bit per cycle), the coarse-to-fine handover runs it twice, and a coarse move
// once tracking runs first passes S_MULT and S_TRACK
// arst_n clears the search state and loads the register defaults
// a result waiting in the output register does not block the next request,
// but the following result waits in S_EMIT until the output register frees
module contrast_af_two_pass_search #(
	parameter int MAX_COARSE_STEPS = cafs_pkg::MAX_COARSE_STEPS_DEF,
	parameter int MAX_FINE_STEPS   = cafs_pkg::MAX_FINE_STEPS_DEF,
	parameter int POS_BITS         = cafs_pkg::POS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cafs_pkg::CFG_IW-1:0]   cfg_idx,
	input  logic [cafs_pkg::CFG_DW-1:0]   cfg_data,
	cafs_item_if.sink                     item,
	cafs_result_if.source                 result
);

	localparam int NMAX = (MAX_COARSE_STEPS > MAX_FINE_STEPS) ?
		MAX_COARSE_STEPS : MAX_FINE_STEPS;
	localparam int NB   = $clog2(NMAX + 1);

	// configuration registers
	logic [POS_BITS-1:0]               scan_start_q, scan_end_q;
	logic [cafs_pkg::STEPS_W-1:0]      coarse_steps_q, fine_steps_q;
	logic [cafs_pkg::FV_W-1:0]         min_peak_q;
	logic [cafs_pkg::PCT_W-1:0]        drop_ratio_q;

	// search state
	cafs_pkg::seq_t                    seq_q, seq_d;
	cafs_pkg::phase_t                  phase_q;
	cafs_pkg::call_t                   call_q;
	logic [NB-1:0]                     step_q, pstep_q, idx_q, hi_q;
	logic [cafs_pkg::FV_W-1:0]         peak_q, prev_q, fv_q;
	logic [cafs_pkg::FALL_W-1:0]       fall_q;
	logic [cafs_pkg::SETL_W-1:0]       settle_q;
	logic [POS_BITS-1:0]               wst_q, wend_q;
	logic                              func_q, stop_q;
	logic [cafs_pkg::PROD_W-1:0]       prod_fv_q, prod_pk_q;

	// pending result and output register
	logic                              res_mv_q, res_done_q;
	logic [POS_BITS-1:0]               res_tgt_q;
	logic                              out_valid_q, out_mv_q, out_done_q;
	logic [POS_BITS-1:0]               out_tgt_q;
	logic [cafs_pkg::FV_W-1:0]         out_peak_q;

	logic [NB-1:0]                     n_coarse, n_fine;
	logic                              unit_start, unit_done;
	logic [POS_BITS-1:0]               unit_a, unit_b, unit_pos;
	logic [NB-1:0]                     unit_n;
	logic                              ev_start, ev_quiet, ev_settle, emit_load;
	logic [cafs_pkg::FALL_W-1:0]       fall_inc;
	logic                              f_track, f_ge, f_stop1, f_stop;
	logic [NB-1:0]                     step_inc;
	logic                              c_fall_stop, c_end;
	logic [NB:0]                       ps_p3;
	logic [NB-1:0]                     win_lo, win_hi;

	// step counts clamped to the supported range
	always_comb begin
		if (coarse_steps_q < cafs_pkg::STEPS_W'(cafs_pkg::MIN_COARSE))
			n_coarse = NB'(cafs_pkg::MIN_COARSE);
		else if (32'(coarse_steps_q) > MAX_COARSE_STEPS)
			n_coarse = NB'(MAX_COARSE_STEPS);
		else
			n_coarse = NB'(coarse_steps_q);
		if (fine_steps_q < cafs_pkg::STEPS_W'(cafs_pkg::MIN_FINE))
			n_fine = NB'(cafs_pkg::MIN_FINE);
		else if (32'(fine_steps_q) > MAX_FINE_STEPS)
			n_fine = NB'(MAX_FINE_STEPS);
		else
			n_fine = NB'(fine_steps_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_start_q   <= POS_BITS'(cafs_pkg::SCAN_START_RST);
			scan_end_q     <= POS_BITS'(cafs_pkg::SCAN_END_RST);
			coarse_steps_q <= cafs_pkg::STEPS_W'(cafs_pkg::COARSE_STEPS_RST);
			fine_steps_q   <= cafs_pkg::STEPS_W'(cafs_pkg::FINE_STEPS_RST);
			min_peak_q     <= cafs_pkg::FV_W'(cafs_pkg::MIN_PEAK_RST);
			drop_ratio_q   <= cafs_pkg::PCT_W'(cafs_pkg::DROP_RATIO_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cafs_pkg::CFG_SCAN_START:   scan_start_q   <= cfg_data[POS_BITS-1:0];
				cafs_pkg::CFG_SCAN_END:     scan_end_q     <= cfg_data[POS_BITS-1:0];
				cafs_pkg::CFG_COARSE_STEPS: coarse_steps_q <= cfg_data[cafs_pkg::STEPS_W-1:0];
				cafs_pkg::CFG_FINE_STEPS:   fine_steps_q   <= cfg_data[cafs_pkg::STEPS_W-1:0];
				cafs_pkg::CFG_MIN_PEAK:     min_peak_q     <= cfg_data[cafs_pkg::FV_W-1:0];
				cafs_pkg::CFG_DROP_RATIO:   drop_ratio_q   <= cfg_data[cafs_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// shared interpolation unit
	assign unit_a = (call_q == cafs_pkg::CALL_FPOS) ? wst_q : scan_start_q;
	assign unit_b = (call_q == cafs_pkg::CALL_FPOS) ? wend_q : scan_end_q;
	assign unit_n = (call_q == cafs_pkg::CALL_FPOS) ? n_fine : n_coarse;

	cafs_interp #(
		.POS_BITS (POS_BITS),
		.NB       (NB)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.a      (unit_a),
		.b      (unit_b),
		.idx    (idx_q),
		.n      (unit_n),
		.done   (unit_done),
		.pos    (unit_pos)
	);

	// request classification
	assign ev_start  = func_q == cafs_pkg::FUNC_START;
	assign ev_quiet  = (phase_q == cafs_pkg::PH_IDLE) || (phase_q == cafs_pkg::PH_DONE);
	assign ev_settle = settle_q != '0;
	assign emit_load = (seq_q == cafs_pkg::S_EMIT) && (!out_valid_q || result.ready);

	// fall counter saturates
	assign fall_inc = (fall_q == cafs_pkg::FALL_W'(cafs_pkg::FALL_MAX)) ?
		fall_q : fall_q + 1'b1;

	// fine scan decision
	assign f_track  = step_q >= NB'(cafs_pkg::TRACK_FROM);
	assign f_ge     = fv_q >= peak_q;
	assign f_stop1  = f_track && !f_ge && (fall_inc >= cafs_pkg::FALL_W'(cafs_pkg::FALL_LIMIT));
	assign step_inc = step_q + 1'b1;
	assign f_stop   = f_stop1 || (step_inc >= n_fine);

	// coarse early stop, products registered in S_MULT
	assign c_fall_stop = (fall_inc >= cafs_pkg::FALL_W'(cafs_pkg::FALL_LIMIT)) &&
		(prod_fv_q <= prod_pk_q) && (peak_q >= min_peak_q);
	assign c_end = stop_q || (step_q >= n_coarse);

	// refinement window around the coarse peak
	assign ps_p3 = {1'b0, pstep_q} + (NB+1)'(cafs_pkg::WIN_HIGH_EDGE);
	always_comb begin
		if (pstep_q < NB'(cafs_pkg::WIN_LOW_EDGE)) begin
			win_lo = '0;
			win_hi = NB'(cafs_pkg::WIN_SPAN);
		end else if (ps_p3 >= {1'b0, n_coarse}) begin
			win_lo = n_coarse - NB'(cafs_pkg::WIN_SPAN);
			win_hi = n_coarse;
		end else begin
			win_lo = pstep_q - 1'b1;
			win_hi = pstep_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_q <= cafs_pkg::S_IDLE;
		else
			seq_q <= seq_d;
	end

	always_comb begin
		seq_d      = seq_q;
		unit_start = 1'b0;
		item.ready = 1'b0;
		unique case (seq_q)
			cafs_pkg::S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid)
					seq_d = cafs_pkg::S_EVAL;
			end
			cafs_pkg::S_EVAL: begin
				if (ev_start || ev_quiet || ev_settle)
					seq_d = cafs_pkg::S_EMIT;
				else if (phase_q == cafs_pkg::PH_COARSE)
					seq_d = (step_q >= NB'(cafs_pkg::TRACK_FROM)) ?
						cafs_pkg::S_MULT : cafs_pkg::S_DECIDE;
				else
					seq_d = cafs_pkg::S_CALL;
			end
			cafs_pkg::S_MULT:   seq_d = cafs_pkg::S_TRACK;
			cafs_pkg::S_TRACK:  seq_d = cafs_pkg::S_DECIDE;
			cafs_pkg::S_DECIDE: seq_d = cafs_pkg::S_CALL;
			cafs_pkg::S_CALL: begin
				unit_start = 1'b1;
				seq_d      = cafs_pkg::S_WAIT;
			end
			cafs_pkg::S_WAIT: begin
				if (unit_done)
					seq_d = (call_q == cafs_pkg::CALL_WLO) ?
						cafs_pkg::S_CALL : cafs_pkg::S_EMIT;
			end
			cafs_pkg::S_EMIT: begin
				if (emit_load)
					seq_d = cafs_pkg::S_IDLE;
			end
			default: seq_d = cafs_pkg::S_IDLE;
		endcase
	end

	// search state and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cafs_pkg::PH_IDLE;
			step_q   <= '0;
			pstep_q  <= '0;
			peak_q   <= '0;
			prev_q   <= '0;
			fall_q   <= '0;
			settle_q <= '0;
			wst_q    <= '0;
			wend_q   <= '0;
			call_q   <= cafs_pkg::CALL_POS;
		end else begin
			unique case (seq_q)
				cafs_pkg::S_IDLE: begin
					if (item.valid) begin
						func_q <= item.func;
						fv_q   <= item.focus_value;
					end
				end
				cafs_pkg::S_EVAL: begin
					res_mv_q   <= 1'b0;
					res_tgt_q  <= '0;
					res_done_q <= 1'b0;
					if (ev_start) begin
						phase_q   <= cafs_pkg::PH_COARSE;
						step_q    <= '0;
						pstep_q   <= '0;
						peak_q    <= '0;
						prev_q    <= '0;
						fall_q    <= '0;
						settle_q  <= cafs_pkg::SETL_W'(cafs_pkg::START_SETTLE);
						res_mv_q  <= 1'b1;
						res_tgt_q <= scan_start_q;
					end else if (ev_quiet) begin
						// nothing changes
					end else if (ev_settle) begin
						settle_q <= settle_q - 1'b1;
					end else if (phase_q == cafs_pkg::PH_COARSE) begin
						stop_q <= 1'b0;
					end else begin
						if (f_track && f_ge) begin
							peak_q  <= fv_q;
							fall_q  <= '0;
							pstep_q <= step_q;
						end else if (f_track) begin
							fall_q <= fall_inc;
						end
						if (!f_stop1)
							step_q <= step_inc;
						res_mv_q <= 1'b1;
						call_q   <= cafs_pkg::CALL_FPOS;
						if (f_stop) begin
							phase_q    <= cafs_pkg::PH_DONE;
							settle_q   <= '0;
							res_done_q <= 1'b1;
							idx_q      <= (f_track && f_ge) ? step_q : pstep_q;
						end else begin
							settle_q <= cafs_pkg::SETL_W'(cafs_pkg::MOVE_SETTLE);
							idx_q    <= step_inc;
						end
					end
				end
				cafs_pkg::S_MULT: begin
					prod_fv_q <= fv_q * cafs_pkg::PCT_W'(cafs_pkg::PCT_SCALE);
					prod_pk_q <= drop_ratio_q * peak_q;
				end
				cafs_pkg::S_TRACK: begin
					stop_q <= 1'b0;
					if (fv_q >= peak_q) begin
						peak_q  <= fv_q;
						fall_q  <= '0;
						pstep_q <= step_q;
					end else if (fv_q > prev_q) begin
						// rise after a fall starts a new peak
						peak_q <= '0;
						fall_q <= '0;
					end else begin
						fall_q <= fall_inc;
						stop_q <= c_fall_stop;
					end
					prev_q <= fv_q;
				end
				cafs_pkg::S_DECIDE: begin
					res_mv_q <= 1'b1;
					settle_q <= cafs_pkg::SETL_W'(cafs_pkg::MOVE_SETTLE);
					if (c_end) begin
						idx_q   <= win_lo;
						hi_q    <= win_hi;
						call_q  <= cafs_pkg::CALL_WLO;
						phase_q <= cafs_pkg::PH_FINE;
						peak_q  <= '0;
						pstep_q <= '0;
						step_q  <= '0;
						fall_q  <= '0;
						prev_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
						idx_q  <= step_q + 1'b1;
						call_q <= cafs_pkg::CALL_POS;
					end
				end
				cafs_pkg::S_WAIT: begin
					if (unit_done) begin
						case (call_q)
							cafs_pkg::CALL_WLO: begin
								wst_q  <= unit_pos;
								idx_q  <= hi_q;
								call_q <= cafs_pkg::CALL_WHI;
							end
							cafs_pkg::CALL_WHI: begin
								// first fine position is the window start
								wend_q    <= unit_pos;
								res_tgt_q <= wst_q;
							end
							default: res_tgt_q <= unit_pos;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_mv_q   <= res_mv_q;
			out_tgt_q  <= res_tgt_q;
			out_done_q <= res_done_q;
			out_peak_q <= peak_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.move_valid  = out_mv_q;
	assign result.lens_target = out_tgt_q;
	assign result.done_res    = out_done_q;
	assign result.peak_value  = out_peak_q;

endmodule

// ===== rtl/cafs_checker.sv =====
`timescale 1ns / 1ps

module cafs_checker #(
	parameter int POS_BITS = cafs_pkg::POS_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input logic                result_move_valid,
	input logic [POS_BITS-1:0] result_lens_target,
	input logic                result_done_res
);

	// one request in flight at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request accepted while another is in work");

	// a new result appears only once the block is back to taking requests
	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("result shown while request still in work");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_lens_target) && $stable(result_done_res)
			&& $stable(result_move_valid))
		else $error("stalled result changed");

	// no move means no target and no completion
	a_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_move_valid |->
			!result_done_res && (result_lens_target == '0))
		else $error("idle result carries a target or done");

endmodule

bind contrast_af_two_pass_search cafs_checker #(
	.POS_BITS (POS_BITS)
) u_cafs_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_move_valid  (result.move_valid),
	.result_lens_target (result.lens_target),
	.result_done_res    (result.done_res)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int POS_W        = cafs_pkg::POS_BITS_DEF;
	localparam int FV_MAX       = 32'h7fff_ffff;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 550;

	// indexes past the register list
	localparam logic [cafs_pkg::CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [cafs_pkg::CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                      func;
		logic [cafs_pkg::FV_W-1:0] focus;
	} frame_req_t;

	typedef struct packed {
		logic                      move_valid;
		logic [POS_W-1:0]          lens_target;
		logic                      done_res;
		logic [cafs_pkg::FV_W-1:0] peak_value;
	} lens_cmd_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [cafs_pkg::CFG_IW-1:0] cfg_idx;
	logic [cafs_pkg::CFG_DW-1:0] cfg_data;

	cafs_item_if item_ch();
	cafs_result_if #(.POS_BITS(POS_W)) result_ch();

	contrast_af_two_pass_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	// shadow copy of the registers
	logic [POS_W-1:0]             reg_scan_start;
	logic [POS_W-1:0]             reg_scan_end;
	logic [cafs_pkg::STEPS_W-1:0] reg_coarse_steps;
	logic [cafs_pkg::STEPS_W-1:0] reg_fine_steps;
	logic [cafs_pkg::FV_W-1:0]    reg_min_peak;
	logic [cafs_pkg::PCT_W-1:0]   reg_drop_pct;

	// search state as the block should hold it
	cafs_pkg::phase_t             af_phase;
	logic [cafs_pkg::STEPS_W-1:0] af_step;
	logic [cafs_pkg::STEPS_W-1:0] af_peak_step;
	logic [cafs_pkg::FV_W-1:0]    af_peak;
	logic [cafs_pkg::FV_W-1:0]    af_prev;
	logic [cafs_pkg::FALL_W-1:0]  af_falls;
	logic [cafs_pkg::SETL_W-1:0]  af_settle;
	logic [POS_W-1:0]             af_win_lo;
	logic [POS_W-1:0]             af_win_hi;

	frame_req_t frame_queue[$];
	lens_cmd_t  lens_cmd_expected[$];

	int   tx_idle_pct;
	int   rx_stall_pct;
	int   errors = 0;
	int   results_seen = 0;
	logic hold_go;
	logic hold_used;
	int   hold_cnt;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int clamp_steps(int n, int lo, int hi);
		if (n < lo)
			return lo;
		if (n > hi)
			return hi;
		return n;
	endfunction

	function automatic int coarse_count();
		return clamp_steps(int'(reg_coarse_steps), cafs_pkg::MIN_COARSE,
			cafs_pkg::MAX_COARSE_STEPS_DEF);
	endfunction

	function automatic int fine_count();
		return clamp_steps(int'(reg_fine_steps), cafs_pkg::MIN_FINE,
			cafs_pkg::MAX_FINE_STEPS_DEF);
	endfunction

	// a + round_half_up(i * (b - a) / n), index clamped to n
	function automatic logic [POS_W-1:0] lerp_pos(int a, int b, int i, int n);
		longint num;
		if (i > n)
			i = n;
		num = 2 * longint'(n) * a + 2 * longint'(i) * (b - a) + n;
		if (num < 0)
			return '0;
		return POS_W'(num / (2 * n));
	endfunction

	function automatic logic [POS_W-1:0] coarse_at(int i);
		return lerp_pos(int'(reg_scan_start), int'(reg_scan_end), i, coarse_count());
	endfunction

	function automatic logic [POS_W-1:0] fine_at(int i);
		return lerp_pos(int'(af_win_lo), int'(af_win_hi), i, fine_count());
	endfunction

	function automatic lens_cmd_t af_search_step(frame_req_t r);
		lens_cmd_t c;
		int        n;
		int        p;
		bit        stop;
		c = '0;
		stop = 1'b0;
		if (r.func == cafs_pkg::FUNC_START) begin
			af_phase = cafs_pkg::PH_COARSE;
			af_step = '0;
			af_peak_step = '0;
			af_peak = '0;
			af_prev = '0;
			af_falls = '0;
			af_settle = cafs_pkg::SETL_W'(cafs_pkg::START_SETTLE);
			c.move_valid = 1'b1;
			c.lens_target = coarse_at(0);
		end else if (af_phase == cafs_pkg::PH_COARSE || af_phase == cafs_pkg::PH_FINE) begin
			if (af_settle != 0) begin
				af_settle = af_settle - 1'b1;
			end else if (af_phase == cafs_pkg::PH_COARSE) begin
				n = coarse_count();
				if (af_step >= cafs_pkg::TRACK_FROM) begin
					if (r.focus >= af_peak) begin
						af_peak = r.focus;
						af_falls = '0;
						af_peak_step = af_step;
					end else if (r.focus > af_prev) begin
						// rise after a fall starts a fresh peak
						af_peak = '0;
						af_falls = '0;
					end else begin
						if (af_falls < cafs_pkg::FALL_MAX)
							af_falls = af_falls + 1'b1;
						if (af_falls >= cafs_pkg::FALL_LIMIT
								&& 64'(r.focus) * cafs_pkg::PCT_SCALE
									<= 64'(reg_drop_pct) * af_peak
								&& af_peak >= reg_min_peak)
							stop = 1'b1;
					end
					af_prev = r.focus;
				end
				if (stop || af_step >= n) begin
					p = int'(af_peak_step);
					if (p < cafs_pkg::WIN_LOW_EDGE) begin
						af_win_lo = coarse_at(0);
						af_win_hi = coarse_at(cafs_pkg::WIN_SPAN);
					end else if (p + cafs_pkg::WIN_HIGH_EDGE >= n) begin
						af_win_lo = coarse_at(n - cafs_pkg::WIN_SPAN);
						af_win_hi = coarse_at(n);
					end else begin
						af_win_lo = coarse_at(p - 1);
						af_win_hi = coarse_at(p + 1);
					end
					af_phase = cafs_pkg::PH_FINE;
					af_peak = '0;
					af_peak_step = '0;
					af_step = '0;
					af_falls = '0;
					af_prev = '0;
					af_settle = cafs_pkg::SETL_W'(cafs_pkg::MOVE_SETTLE);
					c.move_valid = 1'b1;
					c.lens_target = fine_at(0);
				end else begin
					af_step = af_step + 1'b1;
					af_settle = cafs_pkg::SETL_W'(cafs_pkg::MOVE_SETTLE);
					c.move_valid = 1'b1;
					c.lens_target = coarse_at(int'(af_step));
				end
			end else begin
				if (af_step >= cafs_pkg::TRACK_FROM) begin
					if (r.focus >= af_peak) begin
						af_peak = r.focus;
						af_falls = '0;
						af_peak_step = af_step;
					end else begin
						if (af_falls < cafs_pkg::FALL_MAX)
							af_falls = af_falls + 1'b1;
						if (af_falls >= cafs_pkg::FALL_LIMIT)
							stop = 1'b1;
					end
				end
				if (!stop) begin
					af_step = af_step + 1'b1;
					if (af_step >= fine_count())
						stop = 1'b1;
				end
				if (stop) begin
					af_phase = cafs_pkg::PH_DONE;
					af_settle = '0;
					c.move_valid = 1'b1;
					c.done_res = 1'b1;
					c.lens_target = fine_at(int'(af_peak_step));
				end else begin
					af_settle = cafs_pkg::SETL_W'(cafs_pkg::MOVE_SETTLE);
					c.move_valid = 1'b1;
					c.lens_target = fine_at(int'(af_step));
				end
			end
		end
		c.peak_value = af_peak;
		return c;
	endfunction

	task automatic report_mismatch(string msg);
		$display("result %0d: %s", results_seen, msg);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic offer;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.func <= cafs_pkg::FUNC_FRAME;
			item_ch.focus_value <= '0;
			af_phase = cafs_pkg::PH_IDLE;
			af_step = '0;
			af_peak_step = '0;
			af_peak = '0;
			af_prev = '0;
			af_falls = '0;
			af_settle = '0;
			af_win_lo = '0;
			af_win_hi = '0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				lens_cmd_expected.push_back(af_search_step(frame_queue.pop_front()));
			// an offered request stays up until it is taken
			if (!(item_ch.valid && !item_ch.ready)) begin
				offer = frame_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct;
				if (offer) begin
					item_ch.valid <= 1'b1;
					item_ch.func <= frame_queue[0].func;
					item_ch.focus_value <= frame_queue[0].focus;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_used <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_cnt <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		lens_cmd_t got;
		lens_cmd_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.move_valid = result_ch.move_valid;
				got.lens_target = result_ch.lens_target;
				got.done_res = result_ch.done_res;
				got.peak_value = result_ch.peak_value;
				results_seen++;
				if (lens_cmd_expected.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = lens_cmd_expected.pop_front();
					if (got.move_valid !== want.move_valid)
						report_mismatch($sformatf("move_valid %0d, expected %0d",
							got.move_valid, want.move_valid));
					if (got.lens_target !== want.lens_target)
						report_mismatch($sformatf("lens_target %0d, expected %0d",
							got.lens_target, want.lens_target));
					if (got.done_res !== want.done_res)
						report_mismatch($sformatf("done_res %0d, expected %0d",
							got.done_res, want.done_res));
					if (got.peak_value !== want.peak_value)
						report_mismatch($sformatf("peak_value %0d, expected %0d",
							got.peak_value, want.peak_value));
				end
			end
			result_ch.ready <= hold_cnt == 0 && $urandom_range(99) >= rx_stall_pct;
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic write_reg(logic [cafs_pkg::CFG_IW-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= cafs_pkg::CFG_DW'(val);
		case (idx)
			cafs_pkg::CFG_SCAN_START:   reg_scan_start = POS_W'(val);
			cafs_pkg::CFG_SCAN_END:     reg_scan_end = POS_W'(val);
			cafs_pkg::CFG_COARSE_STEPS: reg_coarse_steps = cafs_pkg::STEPS_W'(val);
			cafs_pkg::CFG_FINE_STEPS:   reg_fine_steps = cafs_pkg::STEPS_W'(val);
			cafs_pkg::CFG_MIN_PEAK:     reg_min_peak = cafs_pkg::FV_W'(val);
			cafs_pkg::CFG_DROP_RATIO:   reg_drop_pct = cafs_pkg::PCT_W'(val);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(int s0, int s1, int nc, int nf, int mp, int pct);
		write_reg(cafs_pkg::CFG_SCAN_START, s0);
		write_reg(cafs_pkg::CFG_SCAN_END, s1);
		write_reg(cafs_pkg::CFG_COARSE_STEPS, nc);
		write_reg(cafs_pkg::CFG_FINE_STEPS, nf);
		write_reg(cafs_pkg::CFG_MIN_PEAK, mp);
		write_reg(cafs_pkg::CFG_DROP_RATIO, pct);
	endtask

	task automatic wait_drained();
		while (frame_queue.size() != 0 || lens_cmd_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_frame(logic func, int unsigned focus);
		frame_req_t r;
		r.func = func;
		r.focus = cafs_pkg::FV_W'(focus);
		frame_queue.push_back(r);
	endtask

	// start request followed by a focus curve of rising and falling runs
	task automatic queue_search(int frames);
		longint level;
		longint delta;
		longint top;
		int     seg_left;
		bit     rising;
		case ($urandom_range(3))
			0: top = 5000;
			1: top = 300000;
			2: top = FV_MAX;
			default: top = $urandom_range(FV_MAX);
		endcase
		if (top < 8)
			top = 8;
		push_frame(cafs_pkg::FUNC_START, $urandom);
		level = $urandom_range(int'(top / 4));
		seg_left = 0;
		rising = 1'b0;
		delta = 0;
		for (int k = 0; k < frames; k++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(12, 2);
				rising = ($urandom_range(3) == 0) ? rising : !rising;
				delta = $urandom_range(int'(top / 6) + 1);
			end
			seg_left--;
			level = rising ? level + delta : level - delta;
			if (level < 0)
				level = 0;
			if (level > top)
				level = top;
			// now and then a restart lands in the middle of a search
			push_frame(($urandom_range(79) == 0) ? cafs_pkg::FUNC_START : cafs_pkg::FUNC_FRAME,
				int'(level));
		end
	endtask

	function automatic int pick_steps(int lo, int hi);
		case ($urandom_range(7))
			0: return $urandom_range(63);
			1: return lo;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic int pick_pos();
		case ($urandom_range(5))
			0: return 0;
			1: return 1023;
			default: return $urandom_range(1023);
		endcase
	endfunction

	initial begin
		int ph;
		int items_sent;
		int n_search;
		int frames;
		int s0, s1, nc, nf, mp, pct;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_go = 1'b0;
		reg_scan_start = POS_W'(cafs_pkg::SCAN_START_RST);
		reg_scan_end = POS_W'(cafs_pkg::SCAN_END_RST);
		reg_coarse_steps = cafs_pkg::STEPS_W'(cafs_pkg::COARSE_STEPS_RST);
		reg_fine_steps = cafs_pkg::STEPS_W'(cafs_pkg::FINE_STEPS_RST);
		reg_min_peak = cafs_pkg::FV_W'(cafs_pkg::MIN_PEAK_RST);
		reg_drop_pct = cafs_pkg::PCT_W'(cafs_pkg::DROP_RATIO_RST);
		@(posedge arst_n);

		// idle frames under reset defaults, then a minimal reversed search
		push_frame(cafs_pkg::FUNC_FRAME, FV_MAX);
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		wait_drained();
		write_all_regs(1023, 0, 0, 0, 0, 100);
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, $urandom);
		push_frame(cafs_pkg::FUNC_START, FV_MAX);
		push_frame(cafs_pkg::FUNC_START, 0);
		push_frame(cafs_pkg::FUNC_FRAME, FV_MAX);
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		push_frame(cafs_pkg::FUNC_FRAME, $urandom);
		push_frame(cafs_pkg::FUNC_FRAME, 100);
		push_frame(cafs_pkg::FUNC_FRAME, FV_MAX);
		push_frame(cafs_pkg::FUNC_FRAME, 200);
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		push_frame(cafs_pkg::FUNC_FRAME, 300);
		push_frame(cafs_pkg::FUNC_FRAME, FV_MAX);
		// zero focus at the first tracked step makes a zero peak
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		push_frame(cafs_pkg::FUNC_FRAME, FV_MAX);
		push_frame(cafs_pkg::FUNC_FRAME, 1);
		push_frame(cafs_pkg::FUNC_FRAME, 5);
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		push_frame(cafs_pkg::FUNC_FRAME, 7);
		push_frame(cafs_pkg::FUNC_FRAME, FV_MAX);
		push_frame(cafs_pkg::FUNC_FRAME, 0);
		wait_drained();

		items_sent = 0;
		ph = 0;
		while (items_sent < RANDOM_ITEMS) begin
			ph++;
			s0 = pick_pos();
			s1 = pick_pos();
			nc = pick_steps(4, 10);
			nf = pick_steps(2, 6);
			case ($urandom_range(4))
				0: mp = 0;
				1: mp = FV_MAX;
				2: mp = $urandom_range(FV_MAX);
				default: mp = $urandom_range(20000);
			endcase
			case ($urandom_range(5))
				0: pct = 0;
				1: pct = 100;
				2: pct = 127;
				default: pct = $urandom_range(127);
			endcase
			case (ph)
				1: begin
					s0 = 0; s1 = 1023; nc = 32; nf = 32; mp = 0; pct = 100;
				end
				2: begin
					s0 = 1023; s1 = 0; nc = 0; nf = 0; mp = FV_MAX; pct = 127;
				end
				3: begin
					s1 = s0; pct = 0;
				end
				4: begin
					nc = 63; nf = 1;
				end
				6: begin
					nc = 5; nf = 63;
				end
				default: ;
			endcase
			write_all_regs(s0, s1, nc, nf, mp, pct);
			if (ph == 2)
				write_reg(CFG_SPARE_HI, 0);
			case (ph % 5)
				1: begin
					tx_idle_pct <= 87; rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct <= 0; rx_stall_pct <= 87;
				end
				3: begin
					tx_idle_pct <= 24; rx_stall_pct <= 24;
				end
				default: begin
					tx_idle_pct <= 0; rx_stall_pct <= 0;
				end
			endcase
			if (ph == 5)
				hold_go <= 1'b1;
			n_search = (coarse_count() > 16 || fine_count() > 16) ? 1 : $urandom_range(3, 1);
			for (int s = 0; s < n_search; s++) begin
				frames = 6 + 2 * coarse_count() + 2 * fine_count() + $urandom_range(3);
				// a cut-short search leaves the next settings to act mid-search
				if (s == n_search - 1 && $urandom_range(3) == 0)
					frames = $urandom_range(frames, 1);
				queue_search(frames);
				items_sent += frames + 1;
			end
			if ($urandom_range(2) == 0) begin
				for (int k = 0; k < 3; k++)
					push_frame($urandom_range(1), $urandom_range(FV_MAX));
			end
			wait_drained();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
